@@ hdl/fourier_box_cross_sinc_pixel_top_assert.svh @@
// Assertion macros used by the checker module of the sinc pattern generator.
`ifndef FOURIER_BOX_CROSS_SINC_PIXEL_TOP_ASSERT_SVH
`define FOURIER_BOX_CROSS_SINC_PIXEL_TOP_ASSERT_SVH

// Property checked while reset is released.
`define FBCS_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error(msg);

// Property checked on every edge, reset included.
`define FBCS_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

@@ hdl/fbcs_pkg.sv @@
`default_nettype none

package fbcs_pkg;

  localparam int NUM_DIMS_DEF = 2;

  // Configuration register indexes.
  localparam logic [2:0] REG_SHAPE_MODE = 3'd0;
  localparam logic [2:0] REG_CENTER_X   = 3'd1;
  localparam logic [2:0] REG_CENTER_Y   = 3'd2;
  localparam logic [2:0] REG_CENTER_Z   = 3'd3;
  localparam logic [2:0] REG_HALF_LEN_X = 3'd4;
  localparam logic [2:0] REG_HALF_LEN_Y = 3'd5;
  localparam logic [2:0] REG_HALF_LEN_Z = 3'd6;
  localparam logic [2:0] REG_GAIN       = 3'd7;

  localparam logic        MODE_BOX   = 1'b0;
  localparam logic [11:0] CENTER_RST = 12'd128;
  localparam logic [19:0] HALF_RST   = 20'd256;
  localparam logic [31:0] GAIN_RST   = 32'd65536;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [62:0] CAP62   = 63'h4000_0000_0000_0000;
  localparam logic [47:0] OUT_MAX = 48'h7FFF_FFFF_FFFF;

  // Signed Q16 sinc width and the multiplier operand width.
  localparam int S_W = 29;
  localparam int B_W = 30;

  // Restoring dividers retire DIV_BPS quotient bits per stage.
  localparam int DIV_BPS = 2;
  localparam int D1_DW   = 55;
  localparam int D1_ST   = (D1_DW + DIV_BPS - 1) / DIV_BPS;
  localparam int D1_PW   = D1_ST * DIV_BPS;
  localparam int D2_DW   = 58;
  localparam int D2_ST   = (D2_DW + DIV_BPS - 1) / DIV_BPS;
  localparam int D2_PW   = D2_ST * DIV_BPS;

  localparam int TAY_TERMS = 7;
  localparam int SINC_LAT  = D1_ST + D2_ST + 7 + 3 * TAY_TERMS;

  // Taylor divisors (2k)(2k+1) and floor(2^32 / divisor).
  localparam logic [7:0] TAYLOR_DIV [1:TAY_TERMS] = '{
    8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210
  };
  localparam logic [31:0] TAYLOR_RCP [1:TAY_TERMS] = '{
    32'd715827882, 32'd214748364, 32'd102261126, 32'd59652323,
    32'd39045157, 32'd27531841, 32'd20452225
  };

  function automatic int clamp_dims(int nd);
    clamp_dims = (nd < 1) ? 1 : ((nd > 3) ? 3 : nd);
  endfunction

  function automatic int total_lat(int nd);
    total_lat = SINC_LAT + 2 + 3 * clamp_dims(nd);
  endfunction

endpackage

`default_nettype wire

@@ hdl/fbcs_sinc.sv @@
`default_nettype none

module fbcs_sinc
  import fbcs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [11:0]           pos,
  input  wire logic [11:0]           center,
  input  wire logic [19:0]           half_len,
  output logic signed [S_W-1:0]      sinc
);

  typedef struct packed {
    logic [11:0]        ad;
    logic [1:0]         quad;
    logic [31:0]        t2;
    logic signed [33:0] sum;
    logic [31:0]        val;
    logic [29:0]        qe;
  } tay_t;

  logic [11:0] cdiv;
  assign cdiv = (center == 12'd0) ? 12'd1 : center;

  // Distance from center.
  logic [11:0] ad_r;

  // Phase divider: (ad * L) << 23 over the center.
  logic [11:0]      d1_rem_r [0:D1_ST];
  logic [D1_PW-1:0] d1_dvd_r [0:D1_ST];
  logic [31:0]      d1_quo_r [0:D1_ST];
  logic [11:0]      d1_ad_r  [0:D1_ST];
  logic [11:0]      d1_rem_nxt [1:D1_ST];
  logic [D1_PW-1:0] d1_dvd_nxt [1:D1_ST];
  logic [31:0]      d1_quo_nxt [1:D1_ST];

  // Sine front end.
  logic [1:0]  sn_quad_r;
  logic [30:0] sn_t_r;
  logic [11:0] sn_ad_r;
  logic [30:0] y_val;
  logic [62:0] ty_prod;
  logic [61:0] tt_prod;

  tay_t tay_a_r [1:TAY_TERMS];
  tay_t tay_b_r [1:TAY_TERMS];
  tay_t tay_c_r [0:TAY_TERMS];
  tay_t tay_a_nxt [1:TAY_TERMS];
  tay_t tay_b_nxt [1:TAY_TERMS];
  tay_t tay_c_nxt [1:TAY_TERMS];

  logic [30:0] cl_num_r;
  logic [11:0] cl_ad_r;
  logic        cl_neg_r;

  // Sinc divider: (|sin| * c) << 16 over ad * pi.
  logic [43:0]      d2_rem_r [0:D2_ST];
  logic [D2_PW-1:0] d2_dvd_r [0:D2_ST];
  logic [43:0]      d2_dvs_r [0:D2_ST];
  logic [26:0]      d2_quo_r [0:D2_ST];
  logic [11:0]      d2_ad_r  [0:D2_ST];
  logic             d2_neg_r [0:D2_ST];
  logic [43:0]      d2_rem_nxt [1:D2_ST];
  logic [D2_PW-1:0] d2_dvd_nxt [1:D2_ST];
  logic [26:0]      d2_quo_nxt [1:D2_ST];

  logic [31:0] len_prod;
  logic [42:0] nc_prod;

  logic signed [S_W-1:0] sinc_r;

  assign len_prod = 32'(ad_r) * 32'(half_len);
  assign y_val    = d1_quo_r[D1_ST][30] ? (ONE_Q30 - {1'b0, d1_quo_r[D1_ST][29:0]})
                                        : {1'b0, d1_quo_r[D1_ST][29:0]};
  assign ty_prod  = 63'(y_val) * 63'(PI_Q30);
  assign tt_prod  = 62'(sn_t_r) * 62'(sn_t_r);
  assign nc_prod  = 43'(cl_num_r) * 43'(cdiv);

  always_comb begin
    logic [11:0]      rem1;
    logic [12:0]      trial1;
    logic [D1_PW-1:0] dvd1;
    logic [31:0]      quo1;
    for (int j = 1; j <= D1_ST; j++) begin
      rem1 = d1_rem_r[j-1];
      dvd1 = d1_dvd_r[j-1];
      quo1 = d1_quo_r[j-1];
      for (int b = 0; b < DIV_BPS; b++) begin
        trial1 = {rem1, dvd1[D1_PW-1]};
        dvd1   = {dvd1[D1_PW-2:0], 1'b0};
        if (trial1 >= {1'b0, cdiv}) begin
          rem1 = 12'(trial1 - {1'b0, cdiv});
          quo1 = {quo1[30:0], 1'b1};
        end else begin
          rem1 = trial1[11:0];
          quo1 = {quo1[30:0], 1'b0};
        end
      end
      d1_rem_nxt[j] = rem1;
      d1_dvd_nxt[j] = dvd1;
      d1_quo_nxt[j] = quo1;
    end
  end

  // Each Taylor term takes three stages: multiply by t^2, reciprocal
  // multiply, then a one-step correction of the estimated quotient.
  always_comb begin
    logic [63:0] xp;
    logic [63:0] mp;
    logic [37:0] qd;
    logic [37:0] rr;
    logic [29:0] term;
    for (int k = 1; k <= TAY_TERMS; k++) begin
      xp = 64'(tay_c_r[k-1].val) * 64'(tay_c_r[k-1].t2);
      tay_a_nxt[k]     = tay_c_r[k-1];
      tay_a_nxt[k].val = xp[61:30];

      mp = 64'(tay_a_r[k].val) * 64'(TAYLOR_RCP[k]);
      tay_b_nxt[k]    = tay_a_r[k];
      tay_b_nxt[k].qe = mp[61:32];

      qd   = 38'(tay_b_r[k].qe) * 38'(TAYLOR_DIV[k]);
      rr   = 38'(tay_b_r[k].val) - qd;
      term = (rr >= 38'(TAYLOR_DIV[k])) ? tay_b_r[k].qe + 30'd1 : tay_b_r[k].qe;
      tay_c_nxt[k]     = tay_b_r[k];
      tay_c_nxt[k].val = 32'(term);
      if ((k % 2) == 1) begin
        tay_c_nxt[k].sum = tay_b_r[k].sum - 34'(term);
      end else begin
        tay_c_nxt[k].sum = tay_b_r[k].sum + 34'(term);
      end
    end
  end

  always_comb begin
    logic [43:0]      rem2;
    logic [44:0]      trial2;
    logic [D2_PW-1:0] dvd2;
    logic [26:0]      quo2;
    for (int j = 1; j <= D2_ST; j++) begin
      rem2 = d2_rem_r[j-1];
      dvd2 = d2_dvd_r[j-1];
      quo2 = d2_quo_r[j-1];
      for (int b = 0; b < DIV_BPS; b++) begin
        trial2 = {rem2, dvd2[D2_PW-1]};
        dvd2   = {dvd2[D2_PW-2:0], 1'b0};
        if (trial2 >= {1'b0, d2_dvs_r[j-1]}) begin
          rem2 = 44'(trial2 - {1'b0, d2_dvs_r[j-1]});
          quo2 = {quo2[25:0], 1'b1};
        end else begin
          rem2 = trial2[43:0];
          quo2 = {quo2[25:0], 1'b0};
        end
      end
      d2_rem_nxt[j] = rem2;
      d2_dvd_nxt[j] = dvd2;
      d2_quo_nxt[j] = quo2;
    end
  end

  always_ff @(posedge clk) begin
    ad_r <= (pos >= cdiv) ? (pos - cdiv) : (cdiv - pos);

    d1_rem_r[0] <= '0;
    d1_dvd_r[0] <= D1_PW'({len_prod, 23'd0});
    d1_quo_r[0] <= '0;
    d1_ad_r[0]  <= ad_r;
    for (int j = 1; j <= D1_ST; j++) begin
      d1_rem_r[j] <= d1_rem_nxt[j];
      d1_dvd_r[j] <= d1_dvd_nxt[j];
      d1_quo_r[j] <= d1_quo_nxt[j];
      d1_ad_r[j]  <= d1_ad_r[j-1];
    end

    sn_quad_r <= d1_quo_r[D1_ST][31:30];
    sn_t_r    <= ty_prod[61:31];
    sn_ad_r   <= d1_ad_r[D1_ST];

    tay_c_r[0].ad   <= sn_ad_r;
    tay_c_r[0].quad <= sn_quad_r;
    tay_c_r[0].t2   <= tt_prod[61:30];
    tay_c_r[0].sum  <= 34'(sn_t_r);
    tay_c_r[0].val  <= 32'(sn_t_r);
    tay_c_r[0].qe   <= '0;
    for (int k = 1; k <= TAY_TERMS; k++) begin
      tay_a_r[k] <= tay_a_nxt[k];
      tay_b_r[k] <= tay_b_nxt[k];
      tay_c_r[k] <= tay_c_nxt[k];
    end

    if (tay_c_r[TAY_TERMS].sum < 0) begin
      cl_num_r <= '0;
    end else if (tay_c_r[TAY_TERMS].sum > 34'(ONE_Q30)) begin
      cl_num_r <= ONE_Q30;
    end else begin
      cl_num_r <= tay_c_r[TAY_TERMS].sum[30:0];
    end
    cl_ad_r  <= tay_c_r[TAY_TERMS].ad;
    cl_neg_r <= tay_c_r[TAY_TERMS].quad[1];

    d2_rem_r[0] <= '0;
    d2_dvd_r[0] <= D2_PW'({nc_prod[41:0], 16'd0});
    d2_dvs_r[0] <= 44'(cl_ad_r) * 44'(PI_Q30);
    d2_quo_r[0] <= '0;
    d2_ad_r[0]  <= cl_ad_r;
    d2_neg_r[0] <= cl_neg_r;
    for (int j = 1; j <= D2_ST; j++) begin
      d2_rem_r[j] <= d2_rem_nxt[j];
      d2_dvd_r[j] <= d2_dvd_nxt[j];
      d2_dvs_r[j] <= d2_dvs_r[j-1];
      d2_quo_r[j] <= d2_quo_nxt[j];
      d2_ad_r[j]  <= d2_ad_r[j-1];
      d2_neg_r[j] <= d2_neg_r[j-1];
    end

    // At the center itself the sinc takes its limit, the half length.
    if (d2_ad_r[D2_ST] == 12'd0) begin
      sinc_r <= S_W'({half_len, 8'd0});
    end else if (d2_neg_r[D2_ST]) begin
      sinc_r <= -S_W'(d2_quo_r[D2_ST]);
    end else begin
      sinc_r <= S_W'(d2_quo_r[D2_ST]);
    end
  end

  assign sinc = sinc_r;

endmodule

`default_nettype wire

@@ hdl/fourier_box_cross_sinc_pixel_top.sv @@
`default_nettype none

// Separable sinc pattern generator. One pixel coordinate is taken on each cycle
// that start is high; busy never rises, so a new coordinate may follow every
// clock. Each pixel value appears on out_pixel_value for one cycle with
// out_valid, in input order, after passing through the two restoring dividers
// of each dimension, which retire two quotient bits per stage, the three-stage
// Taylor terms of the sine, and three stages per dimension in the product
// chain. Results cannot be held off; the receiver must take each beat.
// Configuration writes are expected only while no pixel is in flight.
module fourier_box_cross_sinc_pixel_top
  import fbcs_pkg::*;
#(
  parameter int NUM_DIMS = NUM_DIMS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [11:0]        in_pos_x,
  input  wire logic [11:0]        in_pos_y,
  input  wire logic [11:0]        in_pos_z,
  output logic                    out_valid,
  output logic signed [47:0]      out_pixel_value,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int ND  = clamp_dims(NUM_DIMS);
  localparam int LAT = total_lat(NUM_DIMS);

  typedef struct packed {
    logic                       neg;
    logic [62:0]                acc;
    logic [61:0]                lo;
    logic [60:0]                hi;
    logic [ND-1:0][B_W-1:0]     bv;
  } mul_t;

  logic        shape_mode_r;
  logic [11:0] center_r   [0:2];
  logic [19:0] half_len_r [0:2];
  logic [31:0] gain_r;

  logic [11:0]           pos_in [0:2];
  logic signed [S_W-1:0] sinc_s [0:ND-1];

  logic        vld_r [0:LAT-1];
  mul_t        mc_r  [0:ND];
  mul_t        ma_r  [0:ND-1];
  mul_t        mb_r  [0:ND-1];
  mul_t        mc0_nxt;
  mul_t        mc_nxt [1:ND];
  mul_t        ma_nxt [0:ND-1];
  mul_t        mb_nxt [0:ND-1];
  logic signed [47:0] out_value_r;
  logic signed [47:0] out_value_nxt;

  assign busy   = 1'b0;
  assign pos_in[0] = in_pos_x;
  assign pos_in[1] = in_pos_y;
  assign pos_in[2] = in_pos_z;

  for (genvar i = 0; i < ND; i++) begin : g_dim
    fbcs_sinc u_sinc (
      .clk      (clk),
      .pos      (pos_in[i]),
      .center   (center_r[i]),
      .half_len (half_len_r[i]),
      .sinc     (sinc_s[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_mode_r <= MODE_BOX;
      for (int i = 0; i < 3; i++) begin
        center_r[i]   <= CENTER_RST;
        half_len_r[i] <= HALF_RST;
      end
      gain_r <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHAPE_MODE: shape_mode_r  <= cfg_data[0];
        REG_CENTER_X:   center_r[0]   <= cfg_data[11:0];
        REG_CENTER_Y:   center_r[1]   <= cfg_data[11:0];
        REG_CENTER_Z:   center_r[2]   <= cfg_data[11:0];
        REG_HALF_LEN_X: half_len_r[0] <= cfg_data[19:0];
        REG_HALF_LEN_Y: half_len_r[1] <= cfg_data[19:0];
        REG_HALF_LEN_Z: half_len_r[2] <= cfg_data[19:0];
        REG_GAIN:       gain_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Both shapes share one multiply chain: the cross passes its sum in the
  // first slot and multiplies by 1.0 in the rest.
  always_comb begin
    logic signed [S_W+1:0] sum;
    logic                  par;
    logic [S_W+1:0]        sum_abs;
    sum = '0;
    par = 1'b0;
    mc0_nxt = '0;
    for (int i = 0; i < ND; i++) begin
      sum = sum + (S_W+2)'(sinc_s[i]);
      par = par ^ sinc_s[i][S_W-1];
      mc0_nxt.bv[i] = sinc_s[i][S_W-1] ? B_W'(-sinc_s[i]) : B_W'(sinc_s[i]);
    end
    sum_abs = sum[S_W+1] ? -sum : sum;
    if (shape_mode_r == MODE_BOX) begin
      mc0_nxt.neg = par;
      mc0_nxt.acc = 63'(gain_r) << ND;
    end else begin
      mc0_nxt.neg = sum[S_W+1];
      mc0_nxt.acc = 63'(gain_r) << 1;
      for (int i = 0; i < ND; i++) begin
        mc0_nxt.bv[i] = (i == 0) ? B_W'(sum_abs) : B_W'(32'd65536);
      end
    end
  end

  always_comb begin
    logic [92:0] full;
    for (int i = 0; i < ND; i++) begin
      ma_nxt[i]    = mc_r[i];
      ma_nxt[i].lo = 62'(mc_r[i].acc[31:0]) * 62'(mc_r[i].bv[i]);
      mb_nxt[i]    = ma_r[i];
      mb_nxt[i].hi = 61'(ma_r[i].acc[62:32]) * 61'(ma_r[i].bv[i]);
      full = {mb_r[i].hi, 32'd0} + 93'(mb_r[i].lo);
      mc_nxt[i+1] = mb_r[i];
      mc_nxt[i+1].acc = (full[92:16] > 77'(CAP62)) ? CAP62 : full[78:16];
    end
  end

  always_comb begin
    logic [47:0] lim;
    logic [47:0] mag;
    lim = mc_r[ND].neg ? OUT_MAX + 48'd1 : OUT_MAX;
    mag = (mc_r[ND].acc > 63'(lim)) ? lim : mc_r[ND].acc[47:0];
    out_value_nxt = mc_r[ND].neg ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= start;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    mc_r[0] <= mc0_nxt;
    for (int i = 0; i < ND; i++) begin
      ma_r[i]   <= ma_nxt[i];
      mb_r[i]   <= mb_nxt[i];
      mc_r[i+1] <= mc_nxt[i+1];
    end
    out_value_r <= out_value_nxt;
  end

  assign out_valid       = vld_r[LAT-1];
  assign out_pixel_value = out_value_r;

endmodule

`default_nettype wire

@@ hdl/fbcs_chk.sv @@
`default_nettype none

`include "fourier_box_cross_sinc_pixel_top_assert.svh"

module fbcs_chk
  import fbcs_pkg::*;
#(
  parameter int NUM_DIMS = NUM_DIMS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  localparam int LAT = total_lat(NUM_DIMS);

  // Every result beat traces back to a start beat a fixed latency earlier.
  `FBCS_ASSERT(a_result_origin, clk, rst_n, (out_valid |-> $past(start, LAT)), "result beat without a matching start beat")

  // The pipeline flushes on reset.
  `FBCS_ASSERT_ALWAYS(a_reset_flush, clk, (!rst_n |=> !out_valid), "result beat right after reset")

  // The pipeline never refuses a coordinate.
  `FBCS_ASSERT(a_never_busy, clk, rst_n, (!busy), "busy raised")

endmodule

bind fourier_box_cross_sinc_pixel_top fbcs_chk #(.NUM_DIMS(NUM_DIMS)) u_fbcs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

`default_nettype wire
